>>> rtl/pdu_pkg.sv
`default_nettype none
package pdu_pkg;

  localparam int TYPE_COUNT_DEF = 4;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int FAC_W = 20;
  localparam int DFM_W = 17;
  localparam int PROD_W = DFM_W + FAC_W;
  localparam int RHOF_W = 32 + FAC_W;
  localparam int SPLIT = RHOF_W / 2;
  localparam int DEN_W = 32 + RHOF_W;
  localparam int M3_W = 50;
  localparam int NUM_SHIFT = 44;
  localparam int QBITS = 63;
  localparam int CBITS = 22;
  localparam logic [31:0] FOURPI_Q28 = 32'd3373259426;
  localparam logic [DFM_W-1:0] ONE_Q16 = 17'd65536;

  typedef enum logic [2:0] {
    REG_MAX_FACTOR  = 3'd0,
    REG_MIN_RADIUS  = 3'd1,
    REG_LATENT_PM   = 3'd2,
    REG_LATENT_EN   = 3'd3,
    REG_DEF_T0      = 3'd4,
    REG_DEF_T1      = 3'd5,
    REG_DEF_T2      = 3'd6,
    REG_DEF_T3      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [16:0] deformation;
    logic [19:0] current_factor;
    logic [1:0]  particle_type;
    logic [47:0] mass;
    logic [31:0] density;
    logic [31:0] radius;
    logic        in_group;
    logic        already_marked;
    logic        last_particle;
  } in_t;

  typedef struct packed {
    logic [31:0] new_radius;
    logic [19:0] new_factor;
    logic        resized;
    logic        mark_full;
    logic [63:0] latent_decrement;
    logic        last_out;
  } out_t;

  typedef struct packed {
    logic [19:0] max_factor;
    logic [31:0] min_radius;
    logic [15:0] latent_per_mass;
    logic        latent_enable;
  } cfg_t;

  typedef struct packed {
    logic [31:0] radius;
    logic [19:0] cur;
    logic [19:0] nf;
    logic        cond;
    logic        mark;
    logic [63:0] lat;
    logic        last;
  } side_t;

endpackage
`default_nettype wire

>>> rtl/pdu_regs.sv
`default_nettype none
module pdu_regs #(
  parameter int TYPE_COUNT = pdu_pkg::TYPE_COUNT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pdu_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [pdu_pkg::DATA_W-1:0]     pwdata,
  output logic      [pdu_pkg::DATA_W-1:0]     prdata,
  output pdu_pkg::cfg_t                       cfg,
  output logic      [TYPE_COUNT-1:0][19:0]    defaults
);
  import pdu_pkg::*;

  logic     wr;
  reg_idx_t idx;

  assign wr  = psel && penable && pwrite;
  assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_factor      <= 20'd98304;
      cfg.min_radius      <= '0;
      cfg.latent_per_mass <= '0;
      cfg.latent_enable   <= 1'b0;
      for (int i = 0; i < TYPE_COUNT; i++) defaults[i] <= 20'd65536;
    end else if (wr) begin
      unique case (idx)
        REG_MAX_FACTOR: cfg.max_factor      <= pwdata[19:0];
        REG_MIN_RADIUS: cfg.min_radius      <= pwdata;
        REG_LATENT_PM:  cfg.latent_per_mass <= pwdata[15:0];
        REG_LATENT_EN:  cfg.latent_enable   <= pwdata[0];
        default: begin
          for (int i = 0; i < TYPE_COUNT; i++)
            if (idx == reg_idx_t'(3'(int'(REG_DEF_T0) + i))) defaults[i] <= pwdata[19:0];
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_MAX_FACTOR: prdata = {12'b0, cfg.max_factor};
      REG_MIN_RADIUS: prdata = cfg.min_radius;
      REG_LATENT_PM:  prdata = {16'b0, cfg.latent_per_mass};
      REG_LATENT_EN:  prdata = {31'b0, cfg.latent_enable};
      default: begin
        for (int i = 0; i < TYPE_COUNT; i++)
          if (idx == reg_idx_t'(3'(int'(REG_DEF_T0) + i))) prdata = {12'b0, defaults[i]};
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/pdu_front.sv
`default_nettype none
module pdu_front #(
  parameter int TYPE_COUNT = pdu_pkg::TYPE_COUNT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  pdu_pkg::in_t                     item,
  input  pdu_pkg::cfg_t                    cfg,
  input  wire logic [TYPE_COUNT-1:0][19:0] defaults,
  output logic                             out_valid,
  output logic      [pdu_pkg::DEN_W-1:0]   den,
  output logic      [pdu_pkg::M3_W-1:0]    m3,
  output pdu_pkg::side_t                   side
);
  import pdu_pkg::*;

  localparam int TIDX_W = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;

  // stage 1 inputs
  logic [1:0]        tsel;
  logic [19:0]       f0;
  logic              neg;
  logic [19:0]       diff;
  logic              active;
  logic              full;

  logic              v1, v2, v3, v4;
  in_t               it1, it2, it3, it4;
  logic [19:0]       f0_1;
  logic              neg1;
  logic [PROD_W-1:0] prod1;
  logic              mark1, mark2, mark3, mark4;
  logic              part1, part2;
  logic [63:0]       lat1, lat2, lat3, lat4;
  logic [19:0]       nf2, nf3, nf4;
  logic [RHOF_W-1:0] p3;
  logic              cond3, cond4;
  logic [M3_W-1:0]   m3_3, m3_4;
  logic [31+SPLIT:0] lo4;
  logic [31+RHOF_W-SPLIT:0] hi4;

  assign tsel   = ({1'b0, item.particle_type} >= 3'(TYPE_COUNT)) ? 2'(TYPE_COUNT - 1)
                                                                  : item.particle_type;
  assign f0     = defaults[tsel[TIDX_W-1:0]];
  assign neg    = cfg.max_factor < f0;
  assign diff   = neg ? (f0 - cfg.max_factor) : (cfg.max_factor - f0);
  assign active = item.in_group && !item.already_marked;
  assign full   = item.deformation >= ONE_Q16;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; out_valid <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    // interpolation product and latent product
    it1   <= item;
    f0_1  <= f0;
    neg1  <= neg;
    prod1 <= PROD_W'(item.deformation) * PROD_W'(diff);
    mark1 <= active && full;
    part1 <= active && !full && (item.deformation != '0);
    lat1  <= (active && full && cfg.latent_enable)
             ? 64'(cfg.latent_per_mass) * 64'(item.mass) : 64'd0;
    // new factor, rounded toward minus infinity
    it2   <= it1;
    mark2 <= mark1;
    part2 <= part1;
    lat2  <= lat1;
    nf2   <= neg1 ? f0_1 - 20'((PROD_W+1)'(prod1) + (PROD_W+1)'(16'hFFFF) >> 16)
                  : f0_1 + 20'(prod1 >> 16);
    // density times factor, 1% rule
    it3   <= it2;
    mark3 <= mark2;
    lat3  <= lat2;
    nf3   <= nf2;
    p3    <= RHOF_W'(it2.density) * RHOF_W'(nf2);
    cond3 <= part2 && (27'(nf2) * 27'd100 > 27'(it2.current_factor) * 27'd101)
             && (it2.density != '0) && (nf2 != '0);
    m3_3  <= M3_W'(it2.mass) + (M3_W'(it2.mass) << 1);
    // 4*pi partial products
    it4   <= it3;
    mark4 <= mark3;
    lat4  <= lat3;
    nf4   <= nf3;
    cond4 <= cond3;
    m3_4  <= m3_3;
    lo4   <= (32+SPLIT)'(FOURPI_Q28) * (32+SPLIT)'(p3[SPLIT-1:0]);
    hi4   <= (32+RHOF_W-SPLIT)'(FOURPI_Q28) * (32+RHOF_W-SPLIT)'(p3[RHOF_W-1:SPLIT]);
    // sum partials into the divisor
    den   <= {hi4, SPLIT'(0)} + DEN_W'(lo4);
    m3    <= m3_4;
    side.radius <= it4.radius;
    side.cur    <= it4.current_factor;
    side.nf     <= nf4;
    side.cond   <= cond4;
    side.mark   <= mark4;
    side.lat    <= lat4;
    side.last   <= it4.last_particle;
  end

endmodule
`default_nettype wire

>>> rtl/pdu_div.sv
`default_nettype none
module pdu_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic [pdu_pkg::DEN_W-1:0] den,
  input  wire logic [pdu_pkg::M3_W-1:0]  m3,
  output logic                           out_valid,
  output logic      [pdu_pkg::QBITS-1:0] q
);
  import pdu_pkg::*;

  // numerator is m3 << NUM_SHIFT; its bits from QBITS up seed the remainder
  logic [DEN_W-1:0] rem  [QBITS];
  logic [DEN_W-1:0] dd   [QBITS];
  logic [M3_W-1:0]  mm   [QBITS];
  logic [QBITS-1:0] qq   [QBITS];
  logic             vld  [QBITS];

  for (genvar k = 0; k < QBITS; k++) begin : g_st
    localparam int J = QBITS - 1 - k;
    logic [DEN_W-1:0] rem_i, den_i;
    logic [M3_W-1:0]  m3_i;
    logic [QBITS-1:0] q_i;
    logic             v_i, nb, ge;
    logic [DEN_W:0]   sh;

    if (k == 0) begin : g_first
      assign rem_i = DEN_W'(m3[M3_W-1:QBITS-NUM_SHIFT]);
      assign den_i = den;
      assign m3_i  = m3;
      assign q_i   = '0;
      assign v_i   = in_valid;
    end else begin : g_next
      assign rem_i = rem[k-1];
      assign den_i = dd[k-1];
      assign m3_i  = mm[k-1];
      assign q_i   = qq[k-1];
      assign v_i   = vld[k-1];
    end

    if (J >= NUM_SHIFT) begin : g_bit
      assign nb = m3_i[J-NUM_SHIFT];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign sh = {rem_i, nb};
    assign ge = sh >= {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else     vld[k] <= v_i;
    end

    always_ff @(posedge clk) begin
      rem[k] <= ge ? DEN_W'(sh - {1'b0, den_i}) : sh[DEN_W-1:0];
      qq[k]  <= q_i | (QBITS'(ge) << J);
      dd[k]  <= den_i;
      mm[k]  <= m3_i;
    end
  end

  assign out_valid = vld[QBITS-1];
  assign q         = qq[QBITS-1];

endmodule
`default_nettype wire

>>> rtl/pdu_cbrt.sv
`default_nettype none
module pdu_cbrt (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic [pdu_pkg::QBITS-1:0] v,
  output logic                           out_valid,
  output logic      [pdu_pkg::CBITS-1:0] root
);
  import pdu_pkg::*;

  localparam int TW = 3 * CBITS + 6;
  localparam int R2W = 2 * CBITS;

  // keep r, r^2 and r^3 so each trial cube is shifts and adds
  logic [CBITS-1:0] rr  [CBITS];
  logic [R2W-1:0]   r2  [CBITS];
  logic [QBITS:0]   r3  [CBITS];
  logic [QBITS-1:0] vv  [CBITS];
  logic             vld [CBITS];

  for (genvar k = 0; k < CBITS; k++) begin : g_st
    localparam int B = CBITS - 1 - k;
    logic [CBITS-1:0] r_i;
    logic [R2W-1:0]   r2_i;
    logic [QBITS:0]   r3_i;
    logic [QBITS-1:0] v_i;
    logic             val_i, ok;
    logic [TW-1:0]    t3;

    if (k == 0) begin : g_first
      assign r_i   = '0;
      assign r2_i  = '0;
      assign r3_i  = '0;
      assign v_i   = v;
      assign val_i = in_valid;
    end else begin : g_next
      assign r_i   = rr[k-1];
      assign r2_i  = r2[k-1];
      assign r3_i  = r3[k-1];
      assign v_i   = vv[k-1];
      assign val_i = vld[k-1];
    end

    assign t3 = TW'(r3_i) + ((TW'(r2_i) + (TW'(r2_i) << 1)) << B)
              + ((TW'(r_i) + (TW'(r_i) << 1)) << (2 * B)) + (TW'(1) << (3 * B));
    assign ok = t3 <= TW'(v_i);

    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else     vld[k] <= val_i;
    end

    always_ff @(posedge clk) begin
      rr[k] <= ok ? (r_i | (CBITS'(1) << B)) : r_i;
      r2[k] <= ok ? R2W'((R2W+2)'(r2_i) + ((R2W+2)'(r_i) << (B + 1))
                         + ((R2W+2)'(1) << (2 * B))) : r2_i;
      r3[k] <= ok ? t3[QBITS:0] : r3_i;
      vv[k] <= v_i;
    end
  end

  assign out_valid = vld[CBITS-1];
  assign root      = rr[CBITS-1];

endmodule
`default_nettype wire

>>> rtl/particle_deformation_update.sv
`default_nettype none
// Particle deformation update.
// Items enter on start/particle; start is taken at every rising edge where
// busy is low, and busy stays low, so a new item may enter every cycle.
// Each item gives one result on result, marked by done for one cycle;
// results leave in arrival order. The receiver cannot hold results off,
// so nothing in the pipe ever stalls. The pipe runs interpolation and
// divisor multiplies, restoring division (one quotient bit a stage),
// cube root (one root bit a stage) and 1 output register. Throughput:
// 1 item per cycle. Registers are written over the APB port (pready
// always high); the user must write them only while no item is in
// flight, as the block does not enforce it. Index i sits at byte address
// 4*i. Reset (rst, synchronous) clears every valid bit and loads the
// register reset values; payload registers are left as they are.
module particle_deformation_update #(
  parameter int TYPE_COUNT = pdu_pkg::TYPE_COUNT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  pdu_pkg::in_t                    particle,
  output logic                            done,
  output pdu_pkg::out_t                   result,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pdu_pkg::ADDR_W-1:0] paddr,
  input  wire logic [pdu_pkg::DATA_W-1:0] pwdata,
  output logic      [pdu_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);
  import pdu_pkg::*;

  localparam int DLY = QBITS + CBITS;
  localparam int LATENCY = 5 + DLY + 1;

  cfg_t                   cfg;
  logic [TYPE_COUNT-1:0][19:0] defaults;
  logic                   fr_valid;
  logic [DEN_W-1:0]       den;
  logic [M3_W-1:0]        m3;
  side_t                  fr_side;
  logic                   dv_valid;
  logic [QBITS-1:0]       vol;
  logic                   cb_valid;
  logic [CBITS-1:0]       root;
  side_t                  side_q [DLY];
  side_t                  sd;
  logic                   res;

  // the pipe never stalls
  assign busy   = 1'b0;
  assign pready = 1'b1;

  pdu_regs #(.TYPE_COUNT(TYPE_COUNT)) u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .cfg, .defaults
  );

  pdu_front #(.TYPE_COUNT(TYPE_COUNT)) u_front (
    .clk, .rst,
    .in_valid  (start && !busy),
    .item      (particle),
    .cfg,
    .defaults,
    .out_valid (fr_valid),
    .den,
    .m3,
    .side      (fr_side)
  );

  pdu_div u_div (
    .clk, .rst,
    .in_valid  (fr_valid),
    .den,
    .m3,
    .out_valid (dv_valid),
    .q         (vol)
  );

  pdu_cbrt u_cbrt (
    .clk, .rst,
    .in_valid  (dv_valid),
    .v         (vol),
    .out_valid (cb_valid),
    .root
  );

  // carry the pass-through fields alongside the divider and root pipes
  always_ff @(posedge clk) begin
    side_q[0] <= fr_side;
    for (int i = 1; i < DLY; i++) side_q[i] <= side_q[i-1];
  end

  assign sd  = side_q[DLY-1];
  // accept the new radius only if it shrinks and stays at or above the floor
  assign res = sd.cond && (32'(root) < sd.radius) && (32'(root) >= cfg.min_radius);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= cb_valid;
  end

  always_ff @(posedge clk) begin
    result.new_radius       <= res ? 32'(root) : sd.radius;
    result.new_factor       <= res ? sd.nf : sd.cur;
    result.resized          <= res;
    result.mark_full        <= sd.mark;
    result.latent_decrement <= sd.lat;
    result.last_out         <= sd.last;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching item");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.resized && result.mark_full))
    else $error("resized and marked together");

  a_latent: assert property (@(posedge clk) disable iff (rst)
    (done && !result.mark_full) |-> (result.latent_decrement == 64'd0))
    else $error("latent decrement on an unmarked particle");

endmodule
`default_nettype wire

>>> verif/particle_deformation_update_tb.sv
`timescale 1ns / 100ps
`default_nettype none

import pdu_pkg::*;

// Scoreboard: keeps its own copy of the registers, predicts each particle's
// outcome and matches results in order.
class deform_scoreboard;
  logic [19:0] max_fac;
  logic [31:0] min_rad;
  logic [15:0] lat_pm;
  logic        lat_en;
  logic [19:0] def_fac [4];
  out_t        pending [$];
  int          errors;

  function void reset_regs();
    max_fac = 20'd98304;
    min_rad = '0;
    lat_pm  = '0;
    lat_en  = 1'b0;
    foreach (def_fac[i]) def_fac[i] = 20'd65536;
  endfunction

  function void set_reg(reg_idx_t idx, logic [31:0] v);
    case (idx)
      REG_MAX_FACTOR: max_fac = v[19:0];
      REG_MIN_RADIUS: min_rad = v;
      REG_LATENT_PM:  lat_pm  = v[15:0];
      REG_LATENT_EN:  lat_en  = v[0];
      default:        def_fac[idx - REG_DEF_T0] = v[19:0];
    endcase
  endfunction

  // Interpolated factor for a partial deformation.
  function logic [19:0] interp(logic [16:0] dfm, logic [1:0] typ);
    logic [63:0] f0, span;
    f0 = def_fac[typ];
    if (max_fac >= f0) begin
      span = dfm * (max_fac - f0);
      return f0 + (span >> 16);
    end else begin
      span = dfm * (f0 - max_fac) + 64'd65535;
      return f0 - (span >> 16);
    end
  endfunction

  // Volume-keeping radius, truncated cube root.
  function logic [63:0] shrink_radius(logic [47:0] m, logic [31:0] rho, logic [19:0] nf);
    logic [127:0] num, den, quo;
    logic [63:0]  vol, root, t;
    num = ({80'd0, m} * 128'd3) << 44;
    den = 128'(FOURPI_Q28) * 128'(rho) * 128'(nf);
    quo = num / den;
    vol = quo[63:0];
    root = '0;
    for (int b = 21; b >= 0; b--) begin
      t = root | (64'd1 << b);
      if (t <= 64'd2642245 && t * t * t <= vol) root = t;
    end
    return root;
  endfunction

  function out_t predict(in_t p);
    out_t        o;
    logic [19:0] nf;
    logic [63:0] r;
    o = '0;
    o.new_radius = p.radius;
    o.new_factor = p.current_factor;
    o.last_out   = p.last_particle;
    if (p.in_group && !p.already_marked) begin
      if (p.deformation >= ONE_Q16) begin
        o.mark_full = 1'b1;
        if (lat_en) o.latent_decrement = 64'(lat_pm) * 64'(p.mass);
      end else if (p.deformation != 0) begin
        nf = interp(p.deformation, p.particle_type);
        if (64'd100 * nf > 64'd101 * p.current_factor && p.density != 0 && nf != 0) begin
          r = shrink_radius(p.mass, p.density, nf);
          if (r < 64'(p.radius) && r >= 64'(min_rad)) begin
            o.new_radius = r[31:0];
            o.new_factor = nf;
            o.resized    = 1'b1;
          end
        end
      end
    end
    return o;
  endfunction

  function void note_particle(in_t p);
    pending.push_back(predict(p));
  endfunction

  function void check_result(out_t got);
    out_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.new_radius !== want.new_radius)
      $display("%0t: new_radius expected %h actual %h", $time, want.new_radius, got.new_radius);
    if (got.new_factor !== want.new_factor)
      $display("%0t: new_factor expected %h actual %h", $time, want.new_factor, got.new_factor);
    if (got.resized !== want.resized)
      $display("%0t: resized expected %b actual %b", $time, want.resized, got.resized);
    if (got.mark_full !== want.mark_full)
      $display("%0t: mark_full expected %b actual %b", $time, want.mark_full, got.mark_full);
    if (got.latent_decrement !== want.latent_decrement)
      $display("%0t: latent_decrement expected %h actual %h", $time,
               want.latent_decrement, got.latent_decrement);
    if (got.last_out !== want.last_out)
      $display("%0t: last_out expected %b actual %b", $time, want.last_out, got.last_out);
    if (got !== want) errors++;
  endfunction
endclass

module particle_deformation_update_tb;
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  in_t                 particle = '0;
  logic                done;
  out_t                result;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  deform_scoreboard sb = new();
  logic             took;   // item accepted at the latest rising edge
  bit               no_gaps = 1'b0;

  particle_deformation_update dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .particle(particle),
    .done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Sample both sides at the rising edge: note accepted items, check results.
  always @(posedge clk) begin
    took = !rst && start && !busy;
    if (took) sb.note_particle(particle);
    if (!rst && done) sb.check_result(result);
  end

  // Present one item and hold it until the block takes it.
  task automatic send_particle(in_t p);
    @(negedge clk);
    start = 1'b1;
    particle = p;
    do begin
      @(posedge clk);
      #1;
    end while (!took);
    // Insert an occasional burst of idle cycles.
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(1, 7) - 1) @(negedge clk);
    end
  endtask

  task automatic release_start();
    @(negedge clk);
    start = 1'b0;
  endtask

  // Write one register over the APB port: setup cycle, then access cycle.
  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_W'(4 * int'(idx));
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    sb.set_reg(idx, v);
  endtask

  // Wait until every result has come back, then let the pipe settle.
  task automatic drain();
    release_start();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic in_t make_particle(logic [16:0] dfm, logic [19:0] cur, logic [1:0] typ,
                                        logic [47:0] m, logic [31:0] rho, logic [31:0] rad,
                                        bit grp, bit mk, bit last);
    in_t p;
    p.deformation = dfm; p.current_factor = cur; p.particle_type = typ;
    p.mass = m; p.density = rho; p.radius = rad;
    p.in_group = grp; p.already_marked = mk; p.last_particle = last;
    return p;
  endfunction

  // Random particle; most are partial deformations likely to reach the resize.
  function automatic in_t random_particle();
    in_t         p;
    logic [63:0] r;
    int          kind;
    p = in_t'($bits(in_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
    kind = $urandom_range(0, 99);
    p.in_group = (kind < 90);
    p.already_marked = (kind >= 85 && kind < 90) ? 1'b1 : 1'b0;
    if (p.deformation > ONE_Q16) p.deformation = $urandom_range(0, 2) ? ONE_Q16 : 17'h1FFFF;
    if (kind < 65) begin
      p.deformation = 17'($urandom_range(1, 65535));
      p.current_factor = $urandom_range(0, 3) ? 20'($urandom_range(0, 70000)) : p.current_factor;
      p.mass = p.mass >> $urandom_range(0, 40);
      if ($urandom_range(0, 1)) p.density = p.density >> $urandom_range(0, 31);
      if (p.density == 0 && $urandom_range(0, 7) != 0) p.density = 32'd1;
      r = sb.shrink_radius(p.mass, p.density, sb.interp(p.deformation, p.particle_type));
      case ($urandom_range(0, 3))
        0: p.radius = r[31:0];
        1: p.radius = r[31:0] + 32'd1;
        default: ;
      endcase
    end else if (kind < 85) begin
      p.deformation = $urandom_range(0, 3) ? ONE_Q16 : 17'h0;
    end
    return p;
  endfunction

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) send_particle(random_particle());
  endtask

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    sb.reset_regs();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed items under reset register values.
    send_particle(make_particle(17'd0, 20'd65536, 2'd0, 48'd1000, 32'd10, 32'd100, 1, 0, 0));
    send_particle(make_particle(17'd1, 20'd0, 2'd1, 48'hFFFF_FFFF_FFFF, 32'd1, 32'hFFFF_FFFF,
                                1, 0, 0));
    send_particle(make_particle(17'd65535, 20'd65536, 2'd2, 48'd123456789, 32'd1000,
                                32'hFFFF_FFFF, 1, 0, 1));
    send_particle(make_particle(17'd32768, 20'd65536, 2'd3, 48'd5000, 32'd0, 32'd100, 1, 0, 0));
    send_particle(make_particle(ONE_Q16, 20'd1, 2'd0, 48'hFFFF_FFFF_FFFF, 32'd5, 32'd7, 1, 0, 0));
    send_particle(make_particle(17'h1FFFF, 20'hFFFFF, 2'd3, 48'd77, 32'hFFFF_FFFF, 32'd0,
                                1, 0, 1));
    send_particle(make_particle(17'd40000, 20'd1000, 2'd1, 48'd99999, 32'd50, 32'hFFFF_FFFF,
                                0, 0, 0));
    send_particle(make_particle(ONE_Q16, 20'd1000, 2'd1, 48'd99999, 32'd50, 32'd9, 1, 1, 1));
    send_particle(make_particle(17'd65535, 20'hFFFFF, 2'd0, 48'd1, 32'hFFFF_FFFF, 32'd3,
                                1, 0, 0));
    random_run(80);
    drain();

    // Latent heat on, widest extremes.
    write_reg(REG_LATENT_EN, 32'd1);
    write_reg(REG_LATENT_PM, 32'hFFFF);
    write_reg(REG_MAX_FACTOR, 32'hFFFFF);
    write_reg(REG_MIN_RADIUS, 32'd0);
    send_particle(make_particle(ONE_Q16, 20'd0, 2'd0, 48'hFFFF_FFFF_FFFF, 32'd1, 32'd1, 1, 0, 0));
    send_particle(make_particle(17'd1, 20'd0, 2'd0, 48'd1000, 32'd1, 32'hFFFF_FFFF, 1, 0, 0));
    random_run(140);
    drain();

    // Defaults above the maximum: interpolation runs downwards; zero factors too.
    write_reg(REG_MAX_FACTOR, 32'd0);
    write_reg(REG_DEF_T0, 32'hFFFFF);
    write_reg(REG_DEF_T1, 32'd0);
    write_reg(REG_DEF_T2, 32'd131072);
    write_reg(REG_DEF_T3, 32'd70000);
    write_reg(REG_MIN_RADIUS, 32'hFFFF_FFFF);
    write_reg(REG_LATENT_PM, 32'd1);
    send_particle(make_particle(17'd1, 20'd0, 2'd1, 48'd500, 32'd3, 32'hFFFF_FFFF, 1, 0, 0));
    send_particle(make_particle(17'd65535, 20'd0, 2'd0, 48'd500, 32'd3, 32'hFFFF_FFFF, 1, 0, 0));
    random_run(140);
    drain();

    // Mid-range random registers.
    write_reg(REG_MAX_FACTOR, 32'($urandom_range(65536, 200000)));
    write_reg(REG_MIN_RADIUS, 32'($urandom_range(0, 5000)));
    write_reg(REG_LATENT_PM, 32'($urandom_range(0, 65535)));
    write_reg(REG_LATENT_EN, 32'd0);
    write_reg(REG_DEF_T0, 32'($urandom_range(0, 98304)));
    write_reg(REG_DEF_T1, 32'($urandom_range(0, 98304)));
    write_reg(REG_DEF_T2, 32'd0);
    write_reg(REG_DEF_T3, 32'd65536);
    random_run(200);
    drain();

    // Last stretch back to back, latent on again.
    write_reg(REG_LATENT_EN, 32'd1);
    write_reg(REG_MAX_FACTOR, 32'd98304);
    write_reg(REG_MIN_RADIUS, 32'd0);
    no_gaps = 1'b1;
    random_run(180);
    drain();

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
